>>> design/c2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants, types and the CORDIC step-angle table for the
// cartesian-to-polar unit.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int CORDIC_STEPS   = 32;
    localparam int PRESCALE_SHIFT = 28;
    localparam int Z_WIDTH        = 32;

    localparam int                  THR_WIDTH = 15;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 15'd1;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [0:0] REG_IDX_ZERO_THR = 1'b0;

    localparam logic [Z_WIDTH-1:0] HALF_TURN_Z = 32'h8000_0000;

    typedef struct packed {
        logic valid;
        logic near_y;
        logic near_x;
        logic x_pos;
        logic y_pos;
    } c2p_ctl_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_WIDTH-1:0] step_angle(input int unsigned idx);
        logic [Z_WIDTH-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> design/c2p_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_in_if / c2p_out_if
// Valid/ready channels carrying a cartesian point in and a polar result out.
// ----------------------------------------------------------------------------
interface c2p_in_if #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] radius;
    logic [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, output radius, output angle, input ready);
    modport sink   (input valid, input radius, input angle, output ready);
endinterface
`default_nettype wire

>>> design/c2p_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_prep
// Two front stages: magnitudes, squares and axis tests, then the squared
// length sum, with the CORDIC start vector folded into the right half-plane.
// ----------------------------------------------------------------------------
module c2p_prep #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     advance,
    input  wire                                     in_valid,
    input  wire  signed [COORD_WIDTH-1:0]           x_coord,
    input  wire  signed [COORD_WIDTH-1:0]           y_coord,
    input  wire         [c2p_pkg::THR_WIDTH-1:0]    thr,
    output c2p_pkg::c2p_ctl_t                       ctl_out,
    output logic signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] x_out,
    output logic signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] y_out,
    output logic        [c2p_pkg::Z_WIDTH-1:0]      z_out,
    output logic        [2*COORD_WIDTH-1:0]         n_out
);

    localparam int CW    = COORD_WIDTH + c2p_pkg::PRESCALE_SHIFT + 2;
    localparam int NW    = 2 * COORD_WIDTH;
    localparam int CMP_W = (COORD_WIDTH > c2p_pkg::THR_WIDTH) ? COORD_WIDTH
                                                               : c2p_pkg::THR_WIDTH;

    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic signed [CW-1:0]   x_ext;
    logic signed [CW-1:0]   y_ext;

    c2p_pkg::c2p_ctl_t         ctl_a_next;
    c2p_pkg::c2p_ctl_t         ctl_a_reg;
    c2p_pkg::c2p_ctl_t         ctl_b_reg;
    logic [NW-1:0]             sqx_a_next;
    logic [NW-1:0]             sqy_a_next;
    logic [NW-1:0]             sqx_a_reg;
    logic [NW-1:0]             sqy_a_reg;
    logic signed [CW-1:0]      x_a_next;
    logic signed [CW-1:0]      y_a_next;
    logic [c2p_pkg::Z_WIDTH-1:0] z_a_next;
    logic signed [CW-1:0]      x_a_reg;
    logic signed [CW-1:0]      y_a_reg;
    logic [c2p_pkg::Z_WIDTH-1:0] z_a_reg;
    logic signed [CW-1:0]      x_b_reg;
    logic signed [CW-1:0]      y_b_reg;
    logic [c2p_pkg::Z_WIDTH-1:0] z_b_reg;
    logic [NW-1:0]             n_b_next;
    logic [NW-1:0]             n_b_reg;

    always_comb
    begin
        ax = x_coord[COORD_WIDTH-1] ? (~x_coord + COORD_WIDTH'(1'b1)) : x_coord;
        ay = y_coord[COORD_WIDTH-1] ? (~y_coord + COORD_WIDTH'(1'b1)) : y_coord;

        sqx_a_next = NW'(ax) * NW'(ax);
        sqy_a_next = NW'(ay) * NW'(ay);

        ctl_a_next.valid  = in_valid;
        ctl_a_next.near_y = CMP_W'(ax) < CMP_W'(thr);
        ctl_a_next.near_x = CMP_W'(ay) < CMP_W'(thr);
        ctl_a_next.x_pos  = !x_coord[COORD_WIDTH-1] && (|x_coord);
        ctl_a_next.y_pos  = !y_coord[COORD_WIDTH-1] && (|y_coord);

        x_ext = {{2{x_coord[COORD_WIDTH-1]}}, x_coord, {c2p_pkg::PRESCALE_SHIFT{1'b0}}};
        y_ext = {{2{y_coord[COORD_WIDTH-1]}}, y_coord, {c2p_pkg::PRESCALE_SHIFT{1'b0}}};

        if (x_coord[COORD_WIDTH-1])
        begin
            x_a_next = -x_ext;
            y_a_next = -y_ext;
            z_a_next = c2p_pkg::HALF_TURN_Z;
        end
        else
        begin
            x_a_next = x_ext;
            y_a_next = y_ext;
            z_a_next = '0;
        end

        n_b_next = sqx_a_reg + sqy_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (advance)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sqx_a_reg <= sqx_a_next;
            sqy_a_reg <= sqy_a_next;
            x_a_reg   <= x_a_next;
            y_a_reg   <= y_a_next;
            z_a_reg   <= z_a_next;
            x_b_reg   <= x_a_reg;
            y_b_reg   <= y_a_reg;
            z_b_reg   <= z_a_reg;
            n_b_reg   <= n_b_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign x_out   = x_b_reg;
    assign y_out   = y_b_reg;
    assign z_out   = z_b_reg;
    assign n_out   = n_b_reg;

endmodule
`default_nettype wire

>>> design/c2p_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_cell
// One link of the chain: a vectoring CORDIC micro-rotation and, in the
// first COORD_WIDTH links, one digit of the integer square root.
// ----------------------------------------------------------------------------
module c2p_cell #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int STEP        = 0
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     advance,
    input  wire  c2p_pkg::c2p_ctl_t                 ctl_in,
    input  wire  signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] x_in,
    input  wire  signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] y_in,
    input  wire         [c2p_pkg::Z_WIDTH-1:0]      z_in,
    input  wire         [2*COORD_WIDTH-1:0]         n_in,
    input  wire         [2*COORD_WIDTH-1:0]         root_in,
    output c2p_pkg::c2p_ctl_t                       ctl_out,
    output logic signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] x_out,
    output logic signed [COORD_WIDTH+c2p_pkg::PRESCALE_SHIFT+1:0] y_out,
    output logic        [c2p_pkg::Z_WIDTH-1:0]      z_out,
    output logic        [2*COORD_WIDTH-1:0]         n_out,
    output logic        [2*COORD_WIDTH-1:0]         root_out
);

    localparam int CW = COORD_WIDTH + c2p_pkg::PRESCALE_SHIFT + 2;
    localparam int NW = 2 * COORD_WIDTH;
    localparam logic [c2p_pkg::Z_WIDTH-1:0] ANG = c2p_pkg::step_angle(STEP);

    c2p_pkg::c2p_ctl_t           ctl_reg;
    logic signed [CW-1:0]        dx;
    logic signed [CW-1:0]        dy;
    logic signed [CW-1:0]        x_next;
    logic signed [CW-1:0]        y_next;
    logic [c2p_pkg::Z_WIDTH-1:0] z_next;
    logic signed [CW-1:0]        x_reg;
    logic signed [CW-1:0]        y_reg;
    logic [c2p_pkg::Z_WIDTH-1:0] z_reg;
    logic [NW-1:0]               n_next;
    logic [NW-1:0]               root_next;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               root_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (y_in[CW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
    end

    generate
        if (STEP < COORD_WIDTH)
        begin : g_root
            localparam int          BIT_POS = NW - 2 - 2 * STEP;
            localparam logic [NW:0] BIT     = {{NW{1'b0}}, 1'b1} << BIT_POS;

            logic [NW:0] trial;

            always_comb
            begin
                trial = {1'b0, root_in} + BIT;
                if ({1'b0, n_in} >= trial)
                begin
                    n_next    = n_in - trial[NW-1:0];
                    root_next = (root_in >> 1) + BIT[NW-1:0];
                end
                else
                begin
                    n_next    = n_in;
                    root_next = root_in >> 1;
                end
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                n_next    = n_in;
                root_next = root_in;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            n_reg    <= n_next;
            root_reg <= root_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign n_out    = n_reg;
    assign root_out = root_reg;

endmodule
`default_nettype wire

>>> design/c2p_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_post
// Final selection of the angle (origin and axis cases, rounding of the
// turn count) and a two-entry output buffer that frees the chain.
// ----------------------------------------------------------------------------
module c2p_post #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  c2p_pkg::c2p_ctl_t              ctl_in,
    input  wire  [c2p_pkg::Z_WIDTH-1:0]          z_in,
    input  wire  [2*COORD_WIDTH-1:0]             root_in,
    input  wire  [c2p_pkg::THR_WIDTH-1:0]        thr,
    output logic                                 advance,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [COORD_WIDTH-1:0]               out_radius,
    output logic [ANGLE_WIDTH-1:0]               out_angle
);

    localparam int CMP_W = (COORD_WIDTH > c2p_pkg::THR_WIDTH) ? COORD_WIDTH
                                                               : c2p_pkg::THR_WIDTH;
    localparam int DROP  = c2p_pkg::Z_WIDTH - ANGLE_WIDTH;

    localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = {{(ANGLE_WIDTH-1){1'b0}}, 1'b1}
                                                     << (ANGLE_WIDTH - 2);
    localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = {{(ANGLE_WIDTH-1){1'b0}}, 1'b1}
                                                     << (ANGLE_WIDTH - 1);
    localparam logic [ANGLE_WIDTH-1:0] ANG_3QUARTER = ANG_HALF | ANG_QUARTER;

    logic [COORD_WIDTH-1:0] r;
    logic [ANGLE_WIDTH-1:0] ang_round;
    logic [COORD_WIDTH-1:0] d_radius;
    logic [ANGLE_WIDTH-1:0] d_angle;
    logic                   push;
    logic                   pop;

    logic [1:0]             count_reg;
    logic [1:0]             count_next;
    logic [COORD_WIDTH-1:0] head_r_reg;
    logic [COORD_WIDTH-1:0] head_r_next;
    logic [ANGLE_WIDTH-1:0] head_a_reg;
    logic [ANGLE_WIDTH-1:0] head_a_next;
    logic [COORD_WIDTH-1:0] tail_r_reg;
    logic [COORD_WIDTH-1:0] tail_r_next;
    logic [ANGLE_WIDTH-1:0] tail_a_reg;
    logic [ANGLE_WIDTH-1:0] tail_a_next;

    generate
        if (DROP > 0)
        begin : g_round
            localparam logic [c2p_pkg::Z_WIDTH:0] HALF_LSB =
                {{c2p_pkg::Z_WIDTH{1'b0}}, 1'b1} << (DROP - 1);

            logic [c2p_pkg::Z_WIDTH:0] z_sum;

            always_comb
            begin
                z_sum     = {1'b0, z_in} + HALF_LSB;
                ang_round = z_sum[c2p_pkg::Z_WIDTH-1:DROP];
            end
        end
        else
        begin : g_exact
            assign ang_round = z_in[ANGLE_WIDTH-1:0];
        end
    endgenerate

    always_comb
    begin
        r = root_in[COORD_WIDTH-1:0];
        if (CMP_W'(r) < CMP_W'(thr))
        begin
            d_radius = '0;
            d_angle  = '0;
        end
        else if (ctl_in.near_y)
        begin
            d_radius = r;
            d_angle  = ctl_in.y_pos ? ANG_QUARTER : ANG_3QUARTER;
        end
        else if (ctl_in.near_x)
        begin
            d_radius = r;
            d_angle  = ctl_in.x_pos ? '0 : ANG_HALF;
        end
        else
        begin
            d_radius = r;
            d_angle  = ang_round;
        end
    end

    assign advance   = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = advance && ctl_in.valid;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next  = count_reg;
        head_r_next = head_r_reg;
        head_a_next = head_a_reg;
        tail_r_next = tail_r_reg;
        tail_a_next = tail_a_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_r_next = d_radius;
                    head_a_next = d_angle;
                    count_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_r_next = d_radius;
                    head_a_next = d_angle;
                end
                else if (push)
                begin
                    tail_r_next = d_radius;
                    tail_a_next = d_angle;
                    count_next  = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_r_next = tail_r_reg;
                    head_a_next = tail_a_reg;
                    count_next  = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_r_reg <= head_r_next;
        head_a_reg <= head_a_next;
        tail_r_reg <= tail_r_next;
        tail_a_reg <= tail_a_next;
    end

    assign out_radius = head_r_reg;
    assign out_angle  = head_a_reg;

endmodule
`default_nettype wire

>>> design/cartesian_to_polar_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_unit
// Converts a signed (x, y) point into radius and angle code.
// ----------------------------------------------------------------------------
// Takes one point per clock and returns one result per point, in order.
// From request to result a point passes two front stages (squares, then the
// squared-length sum), a chain of 32 cells that each perform one CORDIC
// micro-rotation (the first COORD_WIDTH also a square-root digit), and the
// output buffer. The chain sets the latency; throughput is one request per
// cycle, and input stalls only when the two-entry output buffer is full.
// Register zero_threshold (APB byte address 0, reset 1) sets the magnitude
// below which the origin and axis tests apply; write it only while idle.
// ----------------------------------------------------------------------------
module cartesian_to_polar_unit #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    c2p_in_if.sink                                point,
    c2p_out_if.source                             polar,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [c2p_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  wire  [c2p_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [c2p_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready
);

    localparam int CW     = COORD_WIDTH + c2p_pkg::PRESCALE_SHIFT + 2;
    localparam int NW     = 2 * COORD_WIDTH;
    localparam int STEPS  = c2p_pkg::CORDIC_STEPS;
    localparam int CMP_W  = (COORD_WIDTH > c2p_pkg::THR_WIDTH) ? COORD_WIDTH
                                                                : c2p_pkg::THR_WIDTH;

    logic [c2p_pkg::THR_WIDTH-1:0] thr_reg;
    logic                          thr_wr;
    logic                          advance;

    c2p_pkg::c2p_ctl_t           ctl_chain  [0:STEPS];
    logic signed [CW-1:0]        x_chain    [0:STEPS];
    logic signed [CW-1:0]        y_chain    [0:STEPS];
    logic [c2p_pkg::Z_WIDTH-1:0] z_chain    [0:STEPS];
    logic [NW-1:0]               n_chain    [0:STEPS];
    logic [NW-1:0]               root_chain [0:STEPS];

    assign pready = 1'b1;
    assign thr_wr = psel && penable && pwrite && pready
                    && (paddr[2] == c2p_pkg::REG_IDX_ZERO_THR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= c2p_pkg::THR_RESET;
        end
        else if (thr_wr)
        begin
            thr_reg <= pwdata[c2p_pkg::THR_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == c2p_pkg::REG_IDX_ZERO_THR)
        begin
            prdata = {{(c2p_pkg::APB_DATA_WIDTH - c2p_pkg::THR_WIDTH){1'b0}}, thr_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign point.ready = advance;

    c2p_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (point.valid),
        .x_coord  (point.x_coord),
        .y_coord  (point.y_coord),
        .thr      (thr_reg),
        .ctl_out  (ctl_chain[0]),
        .x_out    (x_chain[0]),
        .y_out    (y_chain[0]),
        .z_out    (z_chain[0]),
        .n_out    (n_chain[0])
    );

    assign root_chain[0] = '0;

    generate
        for (genvar i = 0; i < STEPS; i++)
        begin : g_cell
            c2p_cell #(
                .COORD_WIDTH (COORD_WIDTH),
                .STEP        (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .ctl_in   (ctl_chain[i]),
                .x_in     (x_chain[i]),
                .y_in     (y_chain[i]),
                .z_in     (z_chain[i]),
                .n_in     (n_chain[i]),
                .root_in  (root_chain[i]),
                .ctl_out  (ctl_chain[i+1]),
                .x_out    (x_chain[i+1]),
                .y_out    (y_chain[i+1]),
                .z_out    (z_chain[i+1]),
                .n_out    (n_chain[i+1]),
                .root_out (root_chain[i+1])
            );
        end
    endgenerate

    c2p_post #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl_chain[STEPS]),
        .z_in       (z_chain[STEPS]),
        .root_in    (root_chain[STEPS]),
        .thr        (thr_reg),
        .advance    (advance),
        .out_valid  (polar.valid),
        .out_ready  (polar.ready),
        .out_radius (polar.radius),
        .out_angle  (polar.angle)
    );

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !point.ready |-> polar.valid
    ) else $error("input stalled with no result pending");

    a_origin_angle_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        polar.valid && (CMP_W'(polar.radius) < CMP_W'(thr_reg)) |-> (polar.angle == '0)
    ) else $error("radius below threshold with non-zero angle");

    a_ready_rises_after_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        !point.ready && polar.ready |=> point.ready
    ) else $error("input still stalled after a result was taken");

endmodule
`default_nettype wire
